// File: design/ipdfd_pkg.sv
// ----------------------------------------------------------------------------
// ipdfd_pkg
// Shared types and constants for the modem frame demultiplexer.
// ----------------------------------------------------------------------------
package ipdfd_pkg;

  // Parser modes; the unused code behaves as idle.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_LEN  = 2'd1;
  localparam logic [1:0] MODE_PAY  = 2'd2;

  // Destination codes carried on the route field.
  localparam logic [1:0] ROUTE_AT   = 2'd0;
  localparam logic [1:0] ROUTE_PAY  = 2'd1;
  localparam logic [1:0] ROUTE_NONE = 2'd2;

  // Command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int WINDOW_DEPTH = 5;
  localparam int FILL_BITS    = 4;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Frame marker "+IPD," with the oldest character first.
  localparam logic [7:0] MARKER [WINDOW_DEPTH] = '{8'h2B, 8'h49, 8'h50, 8'h44, 8'h2C};

  typedef struct packed {
    logic [1:0] route;
    logic [7:0] out_byte;
    logic       frame_start;
    logic       frame_end;
    logic       length_error;
    logic       empty_frame;
  } ipdfd_result_t;

endpackage

// File: design/ipdfd_parser.sv
// ----------------------------------------------------------------------------
// ipdfd_parser
// Parser state and the per-byte routing decision. The result is formed
// combinationally from the current state and the incoming beat; the state
// advances on each accepted beat.
// ----------------------------------------------------------------------------
module ipdfd_parser
  import ipdfd_pkg::*;
#(
  parameter int LENGTH_BITS      = 32,
  parameter int MAX_LENGTH_CHARS = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          cmd,
  input  logic [7:0]    rx_byte,
  output ipdfd_result_t res
);

  localparam logic [FILL_BITS-1:0] MaxChars  = FILL_BITS'(MAX_LENGTH_CHARS);
  localparam logic [FILL_BITS-1:0] WinFull   = FILL_BITS'(WINDOW_DEPTH);
  localparam logic [LENGTH_BITS-1:0] LenMax  = '1;

  logic [1:0]             mode, mode_next;
  logic [LENGTH_BITS-1:0] bytes_left, bytes_left_next;
  logic [LENGTH_BITS-1:0] length_value, length_value_next;
  logic [FILL_BITS-1:0]   fill_count, fill_count_next;
  logic                   digits_stopped, digits_stopped_next;
  logic [7:0]             window [WINDOW_DEPTH];
  logic                   shift_in;

  logic [LENGTH_BITS+3:0] times_ten;
  logic                   is_digit;
  logic                   marker_hit;
  logic [FILL_BITS-1:0]   idle_fill;

  always_comb begin
    is_digit  = rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
    // value * 10 + digit, with four guard bits to detect overflow
    times_ten = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1)
              + (LENGTH_BITS+4)'(rx_byte[3:0]);
    idle_fill = (fill_count >= WinFull) ? WinFull : FILL_BITS'(fill_count + 1'b1);
    // The window after this byte shifts in, compared with the marker.
    marker_hit = (window[1] == MARKER[0]) && (window[2] == MARKER[1])
              && (window[3] == MARKER[2]) && (window[4] == MARKER[3])
              && (rx_byte == MARKER[4]);
  end

  always_comb begin
    mode_next           = mode;
    bytes_left_next     = bytes_left;
    length_value_next   = length_value;
    fill_count_next     = fill_count;
    digits_stopped_next = digits_stopped;
    shift_in            = 1'b0;
    res                 = '{route: ROUTE_NONE, out_byte: 8'd0, default: 1'b0};

    if (cmd == CMD_CLEAR) begin
      mode_next       = MODE_IDLE;
      bytes_left_next = '0;
    end else begin
      case (mode)
        MODE_LEN: begin
          if (rx_byte == CHAR_COLON) begin
            bytes_left_next = length_value;
            if (length_value != '0) begin
              mode_next = MODE_PAY;
            end else begin
              mode_next       = MODE_IDLE;
              res.empty_frame = 1'b1;
            end
            fill_count_next     = '0;
            length_value_next   = '0;
            digits_stopped_next = 1'b0;
          end else if (fill_count < MaxChars) begin
            shift_in        = 1'b1;
            fill_count_next = FILL_BITS'(fill_count + 1'b1);
            if (!digits_stopped && is_digit) begin
              length_value_next = (times_ten[LENGTH_BITS+3:LENGTH_BITS] != 4'd0)
                                ? LenMax : times_ten[LENGTH_BITS-1:0];
            end else begin
              digits_stopped_next = 1'b1;
            end
          end else begin
            mode_next        = MODE_IDLE;
            fill_count_next  = '0;
            res.length_error = 1'b1;
          end
        end
        MODE_PAY: begin
          res.route    = ROUTE_PAY;
          res.out_byte = rx_byte;
          if (bytes_left <= LENGTH_BITS'(1)) begin
            bytes_left_next = '0;
            mode_next       = MODE_IDLE;
            fill_count_next = '0;
            res.frame_end   = 1'b1;
          end else begin
            bytes_left_next = bytes_left - 1'b1;
          end
        end
        default: begin
          res.route       = ROUTE_AT;
          res.out_byte    = rx_byte;
          shift_in        = 1'b1;
          fill_count_next = idle_fill;
          if (idle_fill >= WinFull && marker_hit) begin
            mode_next           = MODE_LEN;
            fill_count_next     = '0;
            length_value_next   = '0;
            digits_stopped_next = 1'b0;
            res.frame_start     = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      bytes_left     <= '0;
      length_value   <= '0;
      fill_count     <= '0;
      digits_stopped <= 1'b0;
    end else if (step) begin
      mode           <= mode_next;
      bytes_left     <= bytes_left_next;
      length_value   <= length_value_next;
      fill_count     <= fill_count_next;
      digits_stopped <= digits_stopped_next;
    end
  end

  // The window holds no reset; entries only count once the fill count covers them.
  always_ff @(posedge clk) begin
    if (step && shift_in) begin
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[WINDOW_DEPTH-1] <= rx_byte;
    end
  end

  a_start_enters_len: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_start |=> mode == MODE_LEN && fill_count == '0)
    else $error("frame start did not enter length mode");

  a_end_leaves_pay: assert property (@(posedge clk) disable iff (rst)
    step && res.frame_end |=> mode == MODE_IDLE && bytes_left == '0)
    else $error("frame end did not return to idle");

  a_pay_count_live: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_PAY |-> bytes_left != '0)
    else $error("payload mode with an exhausted count");

  a_len_fill_bound: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_LEN |-> fill_count <= MaxChars)
    else $error("length field count beyond its limit");

endmodule

// File: design/ipd_frame_demux.sv
// ----------------------------------------------------------------------------
// ipd_frame_demux
// Tags received modem bytes with their destination stream.
// ----------------------------------------------------------------------------
// Every input beat, a received byte or a clear command, yields exactly one
// registered output beat, and a new beat is taken every cycle while in_stall
// is low. The parser state updates on each accepted byte; the result
// lands in an output register backed by a one-entry skid register, so the
// input keeps accepting while one result waits on a stalled output, and
// in_stall rises only when both registers are full. Bytes in idle mode go to
// the AT-response stream; "+IPD," starts a length field of up to
// MAX_LENGTH_CHARS characters, ':' opens the payload, which is routed to the
// payload stream and counted down to its last byte.
// ----------------------------------------------------------------------------
module ipd_frame_demux
  import ipdfd_pkg::*;
#(
  parameter int LENGTH_BITS      = 32,
  parameter int MAX_LENGTH_CHARS = 10
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] route,
  output logic [7:0] out_byte,
  output logic       frame_start,
  output logic       frame_end,
  output logic       length_error,
  output logic       empty_frame
);

  logic          accept;
  ipdfd_result_t res;
  ipdfd_result_t out_reg;
  ipdfd_result_t skid;
  logic          skid_valid;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;

  ipdfd_parser #(
    .LENGTH_BITS      (LENGTH_BITS),
    .MAX_LENGTH_CHARS (MAX_LENGTH_CHARS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (accept),
    .cmd     (cmd),
    .rx_byte (rx_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload side: the skid entry always drains ahead of any new beat.
  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_reg <= skid_valid ? skid : res;
    end else if (accept) begin
      skid <= res;
    end
  end

  assign route        = out_reg.route;
  assign out_byte     = out_reg.out_byte;
  assign frame_start  = out_reg.frame_start;
  assign frame_end    = out_reg.frame_end;
  assign length_error = out_reg.length_error;
  assign empty_frame  = out_reg.empty_frame;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(skid_valid) |-> $past(out_valid && out_stall && in_valid))
    else $error("skid entry filled without a stalled output");

  a_route_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && route == ROUTE_NONE |-> out_byte == 8'd0)
    else $error("consumed beat carries a byte");

endmodule
